// ===== hw/rtl/csrs_pkg.sv =====
// ----------------------------------------------------------------------------
// csrs_pkg - shared definitions for the CSR sparse matrix store
// Capacity constants, derived widths, status and register codes, and the
// write-port structs of the row pointer table and the entry table.
// ----------------------------------------------------------------------------
package csrs_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_ENTRIES = 256;
  localparam int MAX_COLS    = 1024;

  localparam int ROW_W   = 6;                          // row field
  localparam int COL_W   = 10;                         // col field
  localparam int VAL_W   = 32;                         // value field
  localparam int ROWS_W  = 7;                          // row_count register
  localparam int COLS_W  = 11;                         // column_count register
  localparam int ROW_AW  = $clog2(MAX_ROWS + 1);       // row pointer table address
  localparam int ENT_AW  = $clog2(MAX_ENTRIES);        // entry table address
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);    // entry count / pointers
  localparam int STAT_W  = 2;
  localparam int CFG_IW  = 1;
  localparam int CFG_DW  = 11;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_COL_COUNT = 1'b1;

  localparam logic MODE_READ = 1'b0;

  typedef struct packed {
    logic              we;
    logic [ROW_AW-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
  } row_wr_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ENT_AW-1:0] waddr;
    entry_t            wdata;
  } entry_wr_t;

endpackage

// ===== hw/rtl/csrs_row_table.sv =====
// ----------------------------------------------------------------------------
// csrs_row_table - row start pointer table
// One write and one registered read per cycle. A valid bit per row clears at
// reset so that an unwritten pointer reads as zero.
// ----------------------------------------------------------------------------
module csrs_row_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [csrs_pkg::ROW_AW-1:0] rd_addr,
  input  csrs_pkg::row_wr_t           wr,
  output logic [csrs_pkg::CNT_W-1:0]  rd_data
);

  logic [csrs_pkg::CNT_W-1:0] mem [0:csrs_pkg::MAX_ROWS];
  logic [csrs_pkg::MAX_ROWS:0] valid;
  logic [csrs_pkg::CNT_W-1:0] mem_q;
  logic                       valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.we) begin
      valid[wr.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    mem_q   <= mem[rd_addr];
    valid_q <= valid[rd_addr];
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

// ===== hw/rtl/csrs_entry_table.sv =====
// ----------------------------------------------------------------------------
// csrs_entry_table - column index and value storage
// Single write port and a single registered read port, one access each per
// cycle. Contents are undefined until written.
// ----------------------------------------------------------------------------
module csrs_entry_table (
  input  logic                        clk,
  input  logic [csrs_pkg::ENT_AW-1:0] rd_addr,
  input  csrs_pkg::entry_wr_t         wr,
  output csrs_pkg::entry_t            rd_data
);

  csrs_pkg::entry_t mem [0:csrs_pkg::MAX_ENTRIES-1];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/csr_sparse_matrix_store.sv =====
// ----------------------------------------------------------------------------
// csr_sparse_matrix_store - sparse matrix in compressed sparse row form
// Reads, overwrites, inserts and deletes single elements, returning the
// previous value and a status per item.
// ----------------------------------------------------------------------------
// Usage:
//  - Input items (mode, row, col, value) on in_valid/in_ready; one result
//    (old_value, status) per item on out_valid/out_ready.
//  - Config writes on cfg_valid/cfg_ready (always ready); index 0 is
//    row_count, index 1 column_count. Write only while idle.
//  - in_ready is high only while the sequencer is idle; one item at a time.
//  - An out of range item goes straight to the done state. Otherwise the
//    row pointers are read and the entries of the addressed row are scanned
//    in column order. Inserts and deletes then move the later entries and
//    update the later row pointers (64 - row of them), as the entry table and
//    row pointer table are each walked one location per cycle. in_ready
//    returns in the same cycle that out_valid rises.
//  - The result sits in an output register, so a new item may be accepted
//    while it waits; a finished item then holds in the done state until the
//    register is free.
//  - Reset clears the entry count, the row pointers (via valid bits, no
//    clearing pass) and restores row_count 64, column_count 1024.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_store (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic [csrs_pkg::ROW_W-1:0]         row,
  input  logic [csrs_pkg::COL_W-1:0]         col,
  input  logic signed [csrs_pkg::VAL_W-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [csrs_pkg::VAL_W-1:0]  old_value,
  output logic [csrs_pkg::STAT_W-1:0]        status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [csrs_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [csrs_pkg::CFG_DW-1:0]        cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LO   = 4'd1;
  localparam logic [3:0] S_HI   = 4'd2;
  localparam logic [3:0] S_LIM  = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_ACT  = 4'd5;
  localparam logic [3:0] S_UP   = 4'd6;
  localparam logic [3:0] S_DOWN = 4'd7;
  localparam logic [3:0] S_ROWS = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state;

  logic [csrs_pkg::ROWS_W-1:0] row_count;
  logic [csrs_pkg::COLS_W-1:0] column_count;
  logic [csrs_pkg::CNT_W-1:0]  entry_count;

  // item payload
  logic                        mode_q;
  logic [csrs_pkg::ROW_W-1:0]  row_q;
  logic [csrs_pkg::COL_W-1:0]  col_q;
  logic [csrs_pkg::VAL_W-1:0]  value_q;
  logic [csrs_pkg::VAL_W-1:0]  old_q;
  logic [csrs_pkg::STAT_W-1:0] status_q;
  logic                        found;

  // walk pointers
  logic [csrs_pkg::CNT_W-1:0]  k;
  logic [csrs_pkg::CNT_W-1:0]  hi;
  logic [csrs_pkg::CNT_W-1:0]  p;
  logic [csrs_pkg::ENT_AW-1:0] wa;
  logic [csrs_pkg::ROW_AW-1:0] rwa;
  logic                        pend;
  logic                        up;

  logic [csrs_pkg::CNT_W-1:0]  k_inc;
  logic [csrs_pkg::CNT_W-1:0]  p_dec;
  logic [csrs_pkg::CNT_W-1:0]  p_inc;
  logic                        issue;

  logic [csrs_pkg::ROW_AW-1:0] row_rd_addr;
  logic [csrs_pkg::CNT_W-1:0]  row_rd_data;
  csrs_pkg::row_wr_t           row_wr;
  logic [csrs_pkg::ENT_AW-1:0] ent_rd_addr;
  csrs_pkg::entry_t            ent_rd_data;
  csrs_pkg::entry_wr_t         ent_wr;

  logic accept;
  logic in_range;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign in_range  = ({1'b0, row} < row_count) && ({1'b0, col} < column_count);

  assign k_inc = k + 1'b1;
  assign p_dec = p - 1'b1;
  assign p_inc = p + 1'b1;

  always_comb begin
    unique case (state)
      S_UP:    issue = (p > k);
      S_DOWN:  issue = (p < entry_count);
      S_ROWS:  issue = (p <= csrs_pkg::CNT_W'(csrs_pkg::MAX_ROWS));
      default: issue = 1'b0;
    endcase
  end

  // read address selection
  always_comb begin
    unique case (state)
      S_LO:    row_rd_addr = csrs_pkg::ROW_AW'(row_q);
      S_HI:    row_rd_addr = csrs_pkg::ROW_AW'(row_q) + 1'b1;
      default: row_rd_addr = p[csrs_pkg::ROW_AW-1:0];
    endcase
    unique case (state)
      S_SCAN:  ent_rd_addr = pend ? k_inc[csrs_pkg::ENT_AW-1:0] : k[csrs_pkg::ENT_AW-1:0];
      S_UP:    ent_rd_addr = p_dec[csrs_pkg::ENT_AW-1:0];
      default: ent_rd_addr = p[csrs_pkg::ENT_AW-1:0];
    endcase
  end

  // write ports
  always_comb begin
    ent_wr       = '0;
    row_wr       = '0;
    row_wr.waddr = rwa;
    row_wr.wdata = up ? row_rd_data + 1'b1 : row_rd_data - 1'b1;
    unique case (state)
      S_ACT: begin
        ent_wr.we          = (mode_q != csrs_pkg::MODE_READ) && (value_q != '0) && found;
        ent_wr.waddr       = k[csrs_pkg::ENT_AW-1:0];
        ent_wr.wdata.col   = col_q;
        ent_wr.wdata.value = value_q;
      end
      S_UP: begin
        if (pend) begin
          ent_wr.we    = 1'b1;
          ent_wr.waddr = wa;
          ent_wr.wdata = ent_rd_data;
        end else if (!issue) begin
          // gap is open: drop the new entry in
          ent_wr.we          = 1'b1;
          ent_wr.waddr       = k[csrs_pkg::ENT_AW-1:0];
          ent_wr.wdata.col   = col_q;
          ent_wr.wdata.value = value_q;
        end
      end
      S_DOWN: begin
        ent_wr.we    = pend;
        ent_wr.waddr = wa;
        ent_wr.wdata = ent_rd_data;
      end
      S_ROWS: begin
        row_wr.we = pend;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= csrs_pkg::ROWS_W'(csrs_pkg::MAX_ROWS);
      column_count <= csrs_pkg::COLS_W'(csrs_pkg::MAX_COLS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csrs_pkg::CFG_ROW_COUNT: row_count    <= cfg_data[csrs_pkg::ROWS_W-1:0];
        csrs_pkg::CFG_COL_COUNT: column_count <= cfg_data[csrs_pkg::COLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // in the done state the output register is handled below
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q   <= mode;
            row_q    <= row;
            col_q    <= col;
            value_q  <= value;
            old_q    <= '0;
            found    <= 1'b0;
            status_q <= in_range ? csrs_pkg::ST_OK : csrs_pkg::ST_RANGE;
            state    <= in_range ? S_LO : S_DONE;
          end
        end
        S_LO: begin
          state <= S_HI;
        end
        S_HI: begin
          k     <= row_rd_data;
          state <= S_LIM;
        end
        S_LIM: begin
          hi    <= (row_rd_data < entry_count) ? row_rd_data : entry_count;
          pend  <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!pend) begin
            if (k < hi) begin
              pend <= 1'b1;
            end else begin
              state <= S_ACT;
            end
          end else if (ent_rd_data.col < col_q) begin
            k <= k_inc;
            if (k_inc >= hi) begin
              pend  <= 1'b0;
              state <= S_ACT;
            end
          end else begin
            pend  <= 1'b0;
            found <= (ent_rd_data.col == col_q);
            old_q <= (ent_rd_data.col == col_q) ? ent_rd_data.value : '0;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          pend <= 1'b0;
          if (mode_q == csrs_pkg::MODE_READ) begin
            state <= S_DONE;
          end else if (value_q != '0) begin
            if (found) begin
              state <= S_DONE;
            end else if (entry_count == csrs_pkg::CNT_W'(csrs_pkg::MAX_ENTRIES)) begin
              status_q <= csrs_pkg::ST_FULL;
              state    <= S_DONE;
            end else begin
              p     <= entry_count;
              state <= S_UP;
            end
          end else if (found) begin
            p     <= k_inc;
            state <= S_DOWN;
          end else begin
            state <= S_DONE;
          end
        end
        S_UP: begin
          pend <= issue;
          if (issue) begin
            p  <= p_dec;
            wa <= p[csrs_pkg::ENT_AW-1:0];
          end else if (!pend) begin
            entry_count <= entry_count + 1'b1;
            p           <= csrs_pkg::CNT_W'(row_q) + 1'b1;
            up          <= 1'b1;
            state       <= S_ROWS;
          end
        end
        S_DOWN: begin
          pend <= issue;
          if (issue) begin
            p  <= p_inc;
            wa <= p_dec[csrs_pkg::ENT_AW-1:0];
          end else if (!pend) begin
            entry_count <= entry_count - 1'b1;
            p           <= csrs_pkg::CNT_W'(row_q) + 1'b1;
            up          <= 1'b0;
            state       <= S_ROWS;
          end
        end
        S_ROWS: begin
          pend <= issue;
          if (issue) begin
            p   <= p_inc;
            rwa <= p[csrs_pkg::ROW_AW-1:0];
          end else if (!pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            old_value <= old_q;
            status    <= status_q;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  csrs_row_table u_row_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (row_rd_addr),
    .wr      (row_wr),
    .rd_data (row_rd_data)
  );

  csrs_entry_table u_entry_table (
    .clk     (clk),
    .rd_addr (ent_rd_addr),
    .wr      (ent_wr),
    .rd_data (ent_rd_data)
  );

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= csrs_pkg::CNT_W'(csrs_pkg::MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && entry_count != $past(entry_count)) |->
      ($past(state) == S_UP || $past(state) == S_DOWN))
    else $error("entry count changed outside insert or delete");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && status_q == csrs_pkg::ST_FULL) |->
      entry_count == csrs_pkg::CNT_W'(csrs_pkg::MAX_ENTRIES))
    else $error("full status with room left");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pend) |-> k < hi)
    else $error("row scan past end of row");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && status_q == csrs_pkg::ST_RANGE) |-> old_q == '0)
    else $error("out of range item returns a value");

endmodule
